// ----- hdl/modbus_rtu_master_transaction_top_macros.svh -----
// ----------------------------------------------------------------------------
// Modbus RTU master transaction engine: assertion macros
// Clocked, reset-gated assertion helpers used by the top level.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_MASTER_TRANSACTION_TOP_MACROS_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mrm_pkg.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU master package
// Shared types, codes and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package mrm_pkg;

  localparam int MAX_QUANTITY_DEFAULT = 123;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_BYTE_TIMEOUT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTER_BYTE_TIMEOUT = 1'd1;

  localparam logic [15:0] FIRST_BYTE_TIMEOUT_RESET = 16'd250;
  localparam logic [15:0] INTER_BYTE_TIMEOUT_RESET = 16'd60;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_REG    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADARG  = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_CRC     = 3'd3;
  localparam logic [2:0] ST_PROTO   = 3'd4;
  localparam logic [2:0] ST_EXC     = 3'd5;

  localparam logic [7:0]  FC_READ    = 8'h03;
  localparam logic [7:0]  FC_WRITE   = 8'h06;
  localparam logic [7:0]  FC_EXC_BIT = 8'h80;
  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] TICKS_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RX,
    PH_EXC
  } phase_e_t;

  typedef enum logic [1:0] {
    GRP_FRAME,
    GRP_REG,
    GRP_STATUS
  } grp_kind_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  slave_address;
    logic        op_select;
    logic [15:0] register_address;
    logic [6:0]  register_count;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
  } item_t;

  // One group of results handed from the engine to the emitter.
  typedef struct packed {
    grp_kind_t       kind;
    logic [5:0][7:0] frame;
    logic [15:0]     value;
    logic [6:0]      index;
    logic [2:0]      status;
    logic [7:0]      exc;
  } grp_t;

  // Reflected CRC-16 update over one byte, one shift per bit.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/mrm_cmd_if.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU master command channel
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface mrm_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  slave_address;
  logic        op_select;
  logic [15:0] register_address;
  logic [6:0]  register_count;
  logic [15:0] write_value;
  logic [7:0]  rx_byte;

  modport source (
    output valid, action, slave_address, op_select, register_address,
           register_count, write_value, rx_byte,
    input  ready
  );

  modport sink (
    input  valid, action, slave_address, op_select, register_address,
           register_count, write_value, rx_byte,
    output ready
  );
endinterface

// ----- hdl/mrm_res_if.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU master result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface mrm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [15:0] reg_value;
  logic [6:0]  reg_index;
  logic [2:0]  status;
  logic [7:0]  exception_code;
  logic        last;

  modport source (
    output valid, kind, tx_byte, reg_value, reg_index, status, exception_code, last,
    input  ready
  );

  modport sink (
    input  valid, kind, tx_byte, reg_value, reg_index, status, exception_code, last,
    output ready
  );
endinterface

// ----- hdl/mrm_inreg.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU master input register
// Holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
module mrm_inreg (
  input  logic          clk,
  input  logic          rst,
  mrm_cmd_if.sink       cmd,
  output logic          item_valid,
  output mrm_pkg::item_t item,
  input  logic          take
);

  logic accept;

  assign cmd.ready = !item_valid || take;
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.action           <= cmd.action;
      item.slave_address    <= cmd.slave_address;
      item.op_select        <= cmd.op_select;
      item.register_address <= cmd.register_address;
      item.register_count   <= cmd.register_count;
      item.write_value      <= cmd.write_value;
      item.rx_byte          <= cmd.rx_byte;
    end
  end

endmodule

// ----- hdl/mrm_engine.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU master transaction engine
// Protocol state, response checks, timeouts and configuration registers.
// ----------------------------------------------------------------------------
module mrm_engine #(
  parameter int MAX_QUANTITY = mrm_pkg::MAX_QUANTITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mrm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mrm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                item_valid,
  input  mrm_pkg::item_t                      item,
  output logic                                take,
  input  logic                                grp_free,
  output logic                                grp_load,
  output mrm_pkg::grp_t                       grp
);

  localparam logic [6:0] MaxQuantity = 7'(MAX_QUANTITY);

  logic [15:0] first_byte_timeout;
  logic [15:0] inter_byte_timeout;

  mrm_pkg::phase_e_t phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  byte_counter, byte_counter_next;
  logic [15:0] idle_ticks, idle_ticks_next;
  logic [7:0]  target_slave, target_slave_next;
  logic        op_is_write, op_is_write_next;
  logic [6:0]  expected_count, expected_count_next;
  logic [15:0] target_address, target_address_next;
  logic [15:0] target_value, target_value_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [7:0]  response_code, response_code_next;

  // Decision flags shared by the next-state and output blocks.
  logic        fin;
  logic [2:0]  fin_status;
  logic [7:0]  fin_exc;
  logic        emit_frame;
  logic        emit_reg;
  logic [15:0] reg_value;
  logic [6:0]  reg_index;

  logic [7:0]  b;
  logic [7:0]  fc;
  logic [7:0]  nbytes;
  logic [8:0]  rd_end;
  logic [7:0]  k;
  logic [15:0] crc_fed;
  logic [15:0] ticks_inc;
  logic [15:0] limit;
  logic [15:0] operand;
  logic        bad_count;

  assign take = item_valid && grp_free;

  assign b         = item.rx_byte;
  assign fc        = op_is_write ? mrm_pkg::FC_WRITE : mrm_pkg::FC_READ;
  assign nbytes    = {expected_count, 1'b0};
  assign rd_end    = 9'd3 + {1'b0, nbytes};
  assign k         = byte_counter - 8'd3;
  assign crc_fed   = mrm_pkg::crc_feed(running_crc, b);
  assign ticks_inc = (idle_ticks != mrm_pkg::TICKS_MAX) ? idle_ticks + 16'd1 : idle_ticks;
  assign limit     = (byte_counter == 8'd0) ? first_byte_timeout : inter_byte_timeout;
  assign operand   = item.op_select ? item.write_value : {9'd0, item.register_count};
  assign bad_count = !item.op_select &&
                     ((item.register_count == 7'd0) || (item.register_count > MaxQuantity));

  // Next state and decision flags.
  always_comb begin
    phase_next          = phase;
    running_crc_next    = running_crc;
    byte_counter_next   = byte_counter;
    idle_ticks_next     = idle_ticks;
    target_slave_next   = target_slave;
    op_is_write_next    = op_is_write;
    expected_count_next = expected_count;
    target_address_next = target_address;
    target_value_next   = target_value;
    held_byte_next      = held_byte;
    response_code_next  = response_code;
    fin        = 1'b0;
    fin_status = mrm_pkg::ST_OK;
    fin_exc    = 8'd0;
    emit_frame = 1'b0;
    emit_reg   = 1'b0;
    reg_value  = {held_byte, b};
    reg_index  = k[7:1];

    case (item.action)
      mrm_pkg::ACT_START: begin
        if (bad_count) begin
          fin        = 1'b1;
          fin_status = mrm_pkg::ST_BADARG;
        end else begin
          emit_frame          = 1'b1;
          target_slave_next   = item.slave_address;
          op_is_write_next    = item.op_select;
          target_address_next = item.register_address;
          target_value_next   = item.write_value;
          expected_count_next = item.op_select ? 7'd0 : item.register_count;
          phase_next          = mrm_pkg::PH_RX;
          running_crc_next    = mrm_pkg::CRC_SEED;
          byte_counter_next   = 8'd0;
          idle_ticks_next     = 16'd0;
          held_byte_next      = 8'd0;
          response_code_next  = 8'd0;
        end
      end
      mrm_pkg::ACT_BYTE: begin
        if (phase != mrm_pkg::PH_IDLE) begin
          idle_ticks_next   = 16'd0;
          byte_counter_next = byte_counter + 8'd1;
          if (byte_counter == 8'd0) begin
            running_crc_next = crc_fed;
            if (b != target_slave) begin
              fin        = 1'b1;
              fin_status = mrm_pkg::ST_PROTO;
            end
          end else if (byte_counter == 8'd1) begin
            running_crc_next   = crc_fed;
            response_code_next = b;
            if (b == (fc | mrm_pkg::FC_EXC_BIT)) begin
              phase_next = mrm_pkg::PH_EXC;
            end else if (b != fc) begin
              fin        = 1'b1;
              fin_status = mrm_pkg::ST_PROTO;
            end
          end else if (phase == mrm_pkg::PH_EXC) begin
            if (byte_counter == 8'd2) begin
              running_crc_next   = crc_fed;
              response_code_next = b;
            end else if (byte_counter == 8'd3) begin
              held_byte_next = b;
            end else begin
              fin = 1'b1;
              if ({b, held_byte} == running_crc) begin
                fin_status = mrm_pkg::ST_EXC;
                fin_exc    = response_code;
              end else begin
                fin_status = mrm_pkg::ST_CRC;
              end
            end
          end else if (!op_is_write) begin
            if (byte_counter == 8'd2) begin
              running_crc_next = crc_fed;
              if (b != nbytes) begin
                fin        = 1'b1;
                fin_status = mrm_pkg::ST_PROTO;
              end
            end else if ({1'b0, byte_counter} < rd_end) begin
              running_crc_next = crc_fed;
              if (!k[0]) begin
                held_byte_next = b;
              end else begin
                emit_reg = 1'b1;
              end
            end else if ({1'b0, byte_counter} == rd_end) begin
              held_byte_next = b;
            end else begin
              fin        = 1'b1;
              fin_status = ({b, held_byte} == running_crc) ? mrm_pkg::ST_OK
                                                            : mrm_pkg::ST_CRC;
            end
          end else begin
            if ((byte_counter == 8'd2) || (byte_counter == 8'd4)) begin
              running_crc_next = crc_fed;
              held_byte_next   = b;
            end else if ((byte_counter == 8'd3) || (byte_counter == 8'd5)) begin
              running_crc_next = crc_fed;
              if ({held_byte, b} !=
                  ((byte_counter == 8'd3) ? target_address : target_value)) begin
                fin        = 1'b1;
                fin_status = mrm_pkg::ST_PROTO;
              end
            end else if (byte_counter == 8'd6) begin
              held_byte_next = b;
            end else begin
              fin        = 1'b1;
              fin_status = ({b, held_byte} == running_crc) ? mrm_pkg::ST_OK
                                                            : mrm_pkg::ST_CRC;
            end
          end
        end
      end
      mrm_pkg::ACT_TICK: begin
        if (phase != mrm_pkg::PH_IDLE) begin
          idle_ticks_next = ticks_inc;
          if ((limit != 16'd0) && (ticks_inc >= limit)) begin
            fin        = 1'b1;
            fin_status = mrm_pkg::ST_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase

    if (fin) begin
      phase_next = mrm_pkg::PH_IDLE;
    end
  end

  // Result group handed to the emitter.
  always_comb begin
    grp_load   = take && (fin || emit_frame || emit_reg);
    grp.kind   = mrm_pkg::GRP_STATUS;
    grp.frame  = '0;
    grp.value  = 16'd0;
    grp.index  = 7'd0;
    grp.status = fin_status;
    grp.exc    = fin_exc;
    if (emit_frame) begin
      grp.kind     = mrm_pkg::GRP_FRAME;
      grp.frame[0] = item.slave_address;
      grp.frame[1] = item.op_select ? mrm_pkg::FC_WRITE : mrm_pkg::FC_READ;
      grp.frame[2] = item.register_address[15:8];
      grp.frame[3] = item.register_address[7:0];
      grp.frame[4] = operand[15:8];
      grp.frame[5] = operand[7:0];
    end else if (emit_reg) begin
      grp.kind  = mrm_pkg::GRP_REG;
      grp.value = reg_value;
      grp.index = reg_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_byte_timeout <= mrm_pkg::FIRST_BYTE_TIMEOUT_RESET;
      inter_byte_timeout <= mrm_pkg::INTER_BYTE_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mrm_pkg::REG_FIRST_BYTE_TIMEOUT: first_byte_timeout <= cfg_data;
        mrm_pkg::REG_INTER_BYTE_TIMEOUT: inter_byte_timeout <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mrm_pkg::PH_IDLE;
      running_crc    <= mrm_pkg::CRC_SEED;
      byte_counter   <= 8'd0;
      idle_ticks     <= 16'd0;
      target_slave   <= 8'd0;
      op_is_write    <= 1'b0;
      expected_count <= 7'd0;
      target_address <= 16'd0;
      target_value   <= 16'd0;
      held_byte      <= 8'd0;
      response_code  <= 8'd0;
    end else if (take) begin
      phase          <= phase_next;
      running_crc    <= running_crc_next;
      byte_counter   <= byte_counter_next;
      idle_ticks     <= idle_ticks_next;
      target_slave   <= target_slave_next;
      op_is_write    <= op_is_write_next;
      expected_count <= expected_count_next;
      target_address <= target_address_next;
      target_value   <= target_value_next;
      held_byte      <= held_byte_next;
      response_code  <= response_code_next;
    end
  end

endmodule

// ----- hdl/mrm_emitter.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU master result emitter
// Holds one result group and sends it out one item per cycle while res is
// ready; the request frame's CRC is built a byte at a time as it goes out.
// ----------------------------------------------------------------------------
module mrm_emitter (
  input  logic          clk,
  input  logic          rst,
  input  logic          grp_load,
  input  mrm_pkg::grp_t grp,
  output logic          grp_free,
  mrm_res_if.source     res
);

  logic          busy;
  mrm_pkg::grp_t grp_q;
  logic [2:0]    idx;
  logic [15:0]   frame_crc;
  logic [7:0]    tx_cur;
  logic          is_frame;
  logic          grp_last;
  logic          fire;

  assign is_frame = (grp_q.kind == mrm_pkg::GRP_FRAME);
  assign grp_last = !is_frame || (idx == 3'd7);
  assign fire     = busy && res.ready;
  assign grp_free = !busy || (fire && grp_last);

  always_comb begin
    case (idx)
      3'd6:    tx_cur = frame_crc[7:0];
      3'd7:    tx_cur = frame_crc[15:8];
      default: tx_cur = grp_q.frame[idx];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (grp_load) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (fire && grp_last) begin
      busy <= 1'b0;
    end else if (fire) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      grp_q     <= grp;
      frame_crc <= mrm_pkg::CRC_SEED;
    end else if (fire && is_frame && (idx < 3'd6)) begin
      frame_crc <= mrm_pkg::crc_feed(frame_crc, tx_cur);
    end
  end

  always_comb begin
    res.valid          = busy;
    res.kind           = mrm_pkg::KIND_STATUS;
    res.tx_byte        = 8'd0;
    res.reg_value      = 16'd0;
    res.reg_index      = 7'd0;
    res.status         = 3'd0;
    res.exception_code = 8'd0;
    res.last           = grp_last;
    case (grp_q.kind)
      mrm_pkg::GRP_FRAME: begin
        res.kind    = mrm_pkg::KIND_TX;
        res.tx_byte = tx_cur;
      end
      mrm_pkg::GRP_REG: begin
        res.kind      = mrm_pkg::KIND_REG;
        res.reg_value = grp_q.value;
        res.reg_index = grp_q.index;
      end
      default: begin
        res.kind           = mrm_pkg::KIND_STATUS;
        res.status         = grp_q.status;
        res.exception_code = grp_q.exc;
      end
    endcase
  end

endmodule

// ----- hdl/modbus_rtu_master_transaction_top.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU master transaction engine, top level
// Builds read-holding-register and write-single-register requests and checks
// the slave's response byte by byte.
// ----------------------------------------------------------------------------
// Use: items enter on cmd (valid/ready) and results leave on res (valid/ready).
// An item is a start request, one received bus byte or one time tick. A
// start gives eight transmit-byte results, CRC low byte first, or a single
// bad-argument status; a received byte gives at most one register value or
// one final status; a tick gives at most a timeout status.
// Throughput: one item per cycle while each item yields at most one result
// and res is ready; a start holds the result register while its eight-byte
// frame drains, and the next item waits in the input register meanwhile.
// The timeout limits are written on cfg_write/cfg_index/cfg_data, by the user
// only while idle; the block does not enforce it. Reset (rst, synchronous)
// empties both registers, returns the engine to idle and reloads the timeout
// limits with 250 and 60 ticks. When res stalls, the current result holds
// steady, one more item is taken into the input register and then cmd.ready
// drops until res moves again.
// ----------------------------------------------------------------------------
`include "modbus_rtu_master_transaction_top_macros.svh"

module modbus_rtu_master_transaction_top #(
  parameter int MAX_QUANTITY = mrm_pkg::MAX_QUANTITY_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mrm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrm_pkg::CFG_DATA_W-1:0]  cfg_data,
  mrm_cmd_if.sink                         cmd,
  mrm_res_if.source                       res
);

  // Input register to engine.
  logic           item_valid;
  mrm_pkg::item_t item;
  logic           take;

  // Engine to emitter.
  logic           grp_free;
  logic           grp_load;
  mrm_pkg::grp_t  grp;

  // The input register parts the command side from the engine, so a new item
  // can be taken while the emitter is still delivering earlier results.
  mrm_inreg u_inreg (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // The engine acts on the held item only when the emitter can take the
  // whole group of results that the item causes.
  mrm_engine #(
    .MAX_QUANTITY (MAX_QUANTITY)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .grp_free   (grp_free),
    .grp_load   (grp_load),
    .grp        (grp)
  );

  // The emitter is the result register; frames drain one byte per cycle while res is ready.
  mrm_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .grp_load (grp_load),
    .grp      (grp),
    .grp_free (grp_free),
    .res      (res)
  );

  // A group is never loaded over one whose results are still undelivered.
  `MRM_ASSERT_IMP(a_load_when_free, grp_load, grp_free, "result group overwritten")

  // Register values and statuses are always the only result of their item.
  `MRM_ASSERT_IMP(a_single_is_last, res.valid && (res.kind != mrm_pkg::KIND_TX), res.last, "single result without last")

  // A loaded frame starts on the result channel with the slave address.
  `MRM_ASSERT_NXT(a_frame_head, grp_load && (grp.kind == mrm_pkg::GRP_FRAME), res.valid && (res.kind == mrm_pkg::KIND_TX) && (res.tx_byte == $past(grp.frame[0])), "frame does not start with slave address")

endmodule
